@@ hw/rtl/aapr_pkg.sv @@
// ============================================================================
// aapr_pkg: shared types and constants for the AABB penetration resolver
// Default lane width, axis codes and the control bundle carried down the pipe.
// ============================================================================
package aapr_pkg;

    // Default width of one signed fixed-point coordinate lane (Q12.4).
    localparam int COORD_BITS_DEF = 16;

    // Axis codes as they appear on push_axis.
    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    // Control that travels with each item through the pipe.
    typedef struct packed {
        logic valid;
        logic a_fixed;
        logic b_fixed;
    } ctl_t;

endpackage

@@ hw/rtl/aapr_axis.sv @@
// ============================================================================
// aapr_axis: per-axis separation and depth, two register stages
// Stage 1 forms maxA-minB and maxB-minA; stage 2 takes magnitudes, keeps the
// smaller as the depth and records which side wins for each push direction.
// ============================================================================
module aapr_axis #(
    parameter int COORD_BITS = aapr_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic signed [COORD_BITS-1:0] a_min,
    input  logic signed [COORD_BITS-1:0] a_max,
    input  logic signed [COORD_BITS-1:0] b_min,
    input  logic signed [COORD_BITS-1:0] b_max,
    output logic        [COORD_BITS-1:0] depth,
    output logic                         a_neg,   // A first: push negative
    output logic                         b_neg,   // B first: push negative
    output logic                         olap
);

    logic signed [COORD_BITS:0]   diff1_reg;   // maxA - minB
    logic signed [COORD_BITS:0]   diff2_reg;   // maxB - minA
    logic signed [COORD_BITS:0]   diff1_next;
    logic signed [COORD_BITS:0]   diff2_next;
    logic        [COORD_BITS:0]   abs1;
    logic        [COORD_BITS:0]   abs2;
    logic        [COORD_BITS-1:0] d1;
    logic        [COORD_BITS-1:0] d2;
    logic        [COORD_BITS-1:0] depth_reg;
    logic        [COORD_BITS-1:0] depth_next;
    logic                         a_neg_reg;
    logic                         b_neg_reg;
    logic                         olap_reg;
    logic                         olap_next;

    always_comb
    begin
        diff1_next = {a_max[COORD_BITS-1], a_max} - {b_min[COORD_BITS-1], b_min};
        diff2_next = {b_max[COORD_BITS-1], b_max} - {a_min[COORD_BITS-1], a_min};
    end

    // Magnitudes never exceed 2^C - 1, so the top bit drops cleanly.
    always_comb
    begin
        abs1       = diff1_reg[COORD_BITS] ? (~diff1_reg + 1'b1) : diff1_reg;
        abs2       = diff2_reg[COORD_BITS] ? (~diff2_reg + 1'b1) : diff2_reg;
        d1         = abs1[COORD_BITS-1:0];
        d2         = abs2[COORD_BITS-1:0];
        depth_next = (d1 <= d2) ? d1 : d2;
        olap_next  = !diff1_reg[COORD_BITS] && !diff2_reg[COORD_BITS];
    end

    always_ff @(posedge clk)
    begin
        diff1_reg <= diff1_next;
        diff2_reg <= diff2_next;
        depth_reg <= depth_next;
        a_neg_reg <= (d1 <= d2);
        b_neg_reg <= (d2 <= d1);
        olap_reg  <= olap_next;
    end

    assign depth = depth_reg;
    assign a_neg = a_neg_reg;
    assign b_neg = b_neg_reg;
    assign olap  = olap_reg;

endmodule

@@ hw/rtl/aapr_resolve.sv @@
// ============================================================================
// aapr_resolve: axis choice and displacement, two register stages
// Stage 3 picks the shallowest axis and the push sign of the moving box;
// stage 4 signs the depth, halves it for two free boxes and drives results.
// ============================================================================
module aapr_resolve #(
    parameter int COORD_BITS = aapr_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  aapr_pkg::ctl_t               ctl,
    input  logic [2:0][COORD_BITS-1:0]   depth,
    input  logic [2:0]                   a_neg,
    input  logic [2:0]                   b_neg,
    input  logic [2:0]                   olap,
    output logic                         done,
    output logic                         overlapping,
    output logic [1:0]                   push_axis,
    output logic signed [COORD_BITS:0]   move_a,
    output logic signed [COORD_BITS:0]   move_b
);

    // stage 3
    aapr_pkg::ctl_t               ctl3_reg;
    aapr_pkg::axis_t              axis3_reg;
    aapr_pkg::axis_t              axis3_next;
    logic [COORD_BITS-1:0]        depth3_reg;
    logic [COORD_BITS-1:0]        depth3_next;
    logic                         neg3_reg;
    logic                         neg3_next;
    logic                         ov3_reg;

    // stage 4 (result registers)
    logic                         done_reg;
    logic                         ov4_reg;
    logic [1:0]                   axis4_reg;
    logic [1:0]                   axis4_next;
    logic signed [COORD_BITS:0]   ma_reg;
    logic signed [COORD_BITS:0]   ma_next;
    logic signed [COORD_BITS:0]   mb_reg;
    logic signed [COORD_BITS:0]   mb_next;
    logic signed [COORD_BITS:0]   mag;
    logic signed [COORD_BITS:0]   v;
    logic signed [COORD_BITS:0]   h;

    // Least depth wins; ties go to x, then y.
    always_comb
    begin
        if (depth[0] <= depth[1] && depth[0] <= depth[2])
        begin
            axis3_next = aapr_pkg::AXIS_X;
        end
        else if (depth[1] <= depth[2])
        begin
            axis3_next = aapr_pkg::AXIS_Y;
        end
        else
        begin
            axis3_next = aapr_pkg::AXIS_Z;
        end
        depth3_next = depth[axis3_next];
        // B is the moving box only when A alone is fixed.
        if (ctl.a_fixed && !ctl.b_fixed)
        begin
            neg3_next = b_neg[axis3_next];
        end
        else
        begin
            neg3_next = a_neg[axis3_next];
        end
    end

    always_ff @(posedge clk)
    begin
        axis3_reg  <= axis3_next;
        depth3_reg <= depth3_next;
        neg3_reg   <= neg3_next;
        ov3_reg    <= &olap;
    end

    always_comb
    begin
        mag = $signed({1'b0, depth3_reg});
        v   = neg3_reg ? -mag : mag;
        h   = v >>> 1;
        ma_next = '0;
        mb_next = '0;
        if (ov3_reg)
        begin
            case ({ctl3_reg.a_fixed, ctl3_reg.b_fixed})
                2'b00:
                begin
                    ma_next = h;
                    mb_next = -h;
                end
                2'b01:   ma_next = v;
                2'b10:   mb_next = v;
                default: ;
            endcase
        end
        axis4_next = ov3_reg ? axis3_reg : aapr_pkg::AXIS_X;
    end

    always_ff @(posedge clk)
    begin
        ov4_reg   <= ov3_reg;
        axis4_reg <= axis4_next;
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl3_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl3_reg <= ctl;
            done_reg <= ctl3_reg.valid;
        end
    end

    assign done        = done_reg;
    assign overlapping = ov4_reg;
    assign push_axis   = axis4_reg;
    assign move_a      = ma_reg;
    assign move_b      = mb_reg;

endmodule

@@ hw/rtl/aabb_penetration_resolver.sv @@
// ============================================================================
// aabb_penetration_resolver: minimum translation vector for two AABBs
// Overlap test, per-axis penetration depth and push for a box pair.
// ============================================================================
// Usage
//   Input: drive the four packed corners and the two fixed flags with start
//   high; the item is taken at that edge whenever busy is low. busy is held
//   low: the pipe takes one item every cycle, back to back, without gaps.
//   Output: done is high for exactly one cycle with overlapping, push_axis,
//   move_a and move_b valid in that cycle. The receiver must take the item
//   then; there is no back-pressure and nothing is held.
//   Pipeline: four register stages lie between the accepting edge and
//   done, which rises once the item has passed through all of them.
//   Throughput: one item per clock, fixed by the four-stage pipe
//   (diff, depth, axis select, displacement); items leave in order.
//   Reset: rst_n clears the valid bits of every stage, so items in flight
//   are dropped and done stays low until a new item comes through.
//   Payload registers carry no reset.
// ============================================================================
module aabb_penetration_resolver #(
    parameter int COORD_BITS = aapr_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [3*COORD_BITS-1:0]      box_a_min,
    input  logic [3*COORD_BITS-1:0]      box_a_max,
    input  logic [3*COORD_BITS-1:0]      box_b_min,
    input  logic [3*COORD_BITS-1:0]      box_b_max,
    input  logic                         a_fixed,
    input  logic                         b_fixed,
    output logic                         done,
    output logic                         overlapping,
    output logic [1:0]                   push_axis,
    output logic signed [COORD_BITS:0]   move_a,
    output logic signed [COORD_BITS:0]   move_b
);

    aapr_pkg::ctl_t             ctl_in;
    aapr_pkg::ctl_t             ctl1_reg;   // travels with axis stage 1
    aapr_pkg::ctl_t             ctl2_reg;   // travels with axis stage 2
    logic [2:0][COORD_BITS-1:0] depth;
    logic [2:0]                 a_neg;
    logic [2:0]                 b_neg;
    logic [2:0]                 olap;

    // Fully pipelined: never refuses an item.
    assign busy = 1'b0;

    always_comb
    begin
        ctl_in.valid   = start && !busy;
        ctl_in.a_fixed = a_fixed;
        ctl_in.b_fixed = b_fixed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
        end
    end

    // One depth unit per axis; lane k sits at bits [k*C +: C].
    for (genvar k = 0; k < 3; k++)
    begin : g_axis
        aapr_axis #(
            .COORD_BITS (COORD_BITS)
        ) u_axis (
            .clk   (clk),
            .a_min (box_a_min[k*COORD_BITS +: COORD_BITS]),
            .a_max (box_a_max[k*COORD_BITS +: COORD_BITS]),
            .b_min (box_b_min[k*COORD_BITS +: COORD_BITS]),
            .b_max (box_b_max[k*COORD_BITS +: COORD_BITS]),
            .depth (depth[k]),
            .a_neg (a_neg[k]),
            .b_neg (b_neg[k]),
            .olap  (olap[k])
        );
    end

    // Axis choice and moves; the fixed flags decide which box goes first.
    aapr_resolve #(
        .COORD_BITS (COORD_BITS)
    ) u_resolve (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl2_reg),
        .depth       (depth),
        .a_neg       (a_neg),
        .b_neg       (b_neg),
        .olap        (olap),
        .done        (done),
        .overlapping (overlapping),
        .push_axis   (push_axis),
        .move_a      (move_a),
        .move_b      (move_b)
    );

endmodule

@@ hw/rtl/aapr_checker.sv @@
// ============================================================================
// aapr_checker: port-level checks for the AABB penetration resolver
// Latency, and the move rules for no overlap, both fixed and both free.
// ============================================================================
module aapr_checker #(
    parameter int COORD_BITS = aapr_pkg::COORD_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic                       a_fixed,
    input  logic                       b_fixed,
    input  logic                       done,
    input  logic                       overlapping,
    input  logic [1:0]                 push_axis,
    input  logic signed [COORD_BITS:0] move_a,
    input  logic signed [COORD_BITS:0] move_b
);

    a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("accepted item did not complete in four cycles");

    a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("result without a matching accepted item");

    a_no_olap: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !overlapping) |->
            (push_axis == aapr_pkg::AXIS_X && move_a == '0 && move_b == '0))
        else $error("moves reported for separated boxes");

    a_both_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(a_fixed, 4) && $past(b_fixed, 4)) |->
            (move_a == '0 && move_b == '0))
        else $error("fixed box moved");

    a_both_free: assert property (@(posedge clk) disable iff (!rst_n)
        (done && overlapping && !$past(a_fixed, 4) && !$past(b_fixed, 4)) |->
            (move_b == -move_a))
        else $error("free boxes not pushed apart symmetrically");

endmodule

bind aabb_penetration_resolver aapr_checker #(
    .COORD_BITS (COORD_BITS)
) u_aapr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .a_fixed     (a_fixed),
    .b_fixed     (b_fixed),
    .done        (done),
    .overlapping (overlapping),
    .push_axis   (push_axis),
    .move_a      (move_a),
    .move_b      (move_b)
);

@@ tb/aabb_penetration_resolver_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// aabb_penetration_resolver_tb: self-checking bench for the box-pair resolver
// Drives box pairs through the start/busy command port, predicts overlap,
// push axis and both displacements per item, and checks every done strobe.
// ============================================================================
module aabb_penetration_resolver_tb;

    localparam int CW           = aapr_pkg::COORD_BITS_DEF;   // one coordinate lane
    localparam int BW           = 3 * CW;           // packed xyz corner
    localparam int RANDOM_ITEMS = 340;              // per random phase, two phases
    localparam int QUIET_LIMIT  = 1000;             // cycles with no item moving
    localparam int DRAIN_CYCLES = 8;                // final wait past the 4-stage pipe
    localparam int MAX_REPORTS  = 100;

    // One box pair as it goes onto the ports.
    typedef struct {
        logic [BW-1:0] a_min;
        logic [BW-1:0] a_max;
        logic [BW-1:0] b_min;
        logic [BW-1:0] b_max;
        logic          a_fix;
        logic          b_fix;
    } pair_t;

    // What the block should report for one pair.
    typedef struct {
        logic                 ov;
        aapr_pkg::axis_t      ax;
        logic signed [CW:0]   ma;
        logic signed [CW:0]   mb;
    } outcome_t;

    // Signed push of the first box along the axis of least depth.
    typedef struct {
        aapr_pkg::axis_t ax;
        int              v;
    } push_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    logic [BW-1:0] box_a_min = '0;
    logic [BW-1:0] box_a_max = '0;
    logic [BW-1:0] box_b_min = '0;
    logic [BW-1:0] box_b_max = '0;
    logic          a_fixed = 1'b0;
    logic          b_fixed = 1'b0;
    logic          done;
    logic          overlapping;
    logic [1:0]    push_axis;
    logic signed [CW:0] move_a;
    logic signed [CW:0] move_b;

    pair_t    pair_q[$];     // pairs waiting for the driver
    outcome_t due_q[$];      // predicted outcomes, oldest first

    logic taken = 1'b0;      // the item on the ports went in at the last rising edge
    int   gap_left = 0;
    int   burst_left = 0;
    int   quiet = 0;
    int   errors = 0;
    int   n_reported = 0;
    int   n_sent = 0;
    int   n_checked = 0;
    int   n_overlap = 0;
    int   n_free = 0;
    int   n_afix = 0;
    int   n_bfix = 0;
    int   n_both = 0;

    aabb_penetration_resolver #(
        .COORD_BITS (CW)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .box_a_min   (box_a_min),
        .box_a_max   (box_a_max),
        .box_b_min   (box_b_min),
        .box_b_max   (box_b_max),
        .a_fixed     (a_fixed),
        .b_fixed     (b_fixed),
        .done        (done),
        .overlapping (overlapping),
        .push_axis   (push_axis),
        .move_a      (move_a),
        .move_b      (move_b)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic int lane_of(logic [BW-1:0] c, int k);
        logic signed [CW-1:0] l;
        l = c[k*CW +: CW];
        return int'(l);
    endfunction

    // Depth per axis is min(|maxP-minQ|, |maxQ-minP|); the first term wins ties
    // and pushes P negative. Axis ties go to x, then y.
    function automatic push_t push_along(logic [BW-1:0] pmin, logic [BW-1:0] pmax,
                                         logic [BW-1:0] qmin, logic [BW-1:0] qmax);
        int    d[3];
        int    sg[3];
        int    d1;
        int    d2;
        int    k;
        push_t r;
        for (k = 0; k < 3; k++)
        begin
            d1 = lane_of(pmax, k) - lane_of(qmin, k);
            d2 = lane_of(qmax, k) - lane_of(pmin, k);
            d1 = (d1 < 0) ? -d1 : d1;
            d2 = (d2 < 0) ? -d2 : d2;
            if (d1 <= d2)
            begin
                d[k]  = d1;
                sg[k] = -1;
            end
            else
            begin
                d[k]  = d2;
                sg[k] = 1;
            end
        end
        if (d[0] <= d[1] && d[0] <= d[2])
        begin
            r.ax = aapr_pkg::AXIS_X;
            r.v  = d[0] * sg[0];
        end
        else if (d[1] <= d[2])
        begin
            r.ax = aapr_pkg::AXIS_Y;
            r.v  = d[1] * sg[1];
        end
        else
        begin
            r.ax = aapr_pkg::AXIS_Z;
            r.v  = d[2] * sg[2];
        end
        return r;
    endfunction

    function automatic outcome_t mtv_predict(pair_t p);
        outcome_t o;
        push_t    r;
        int       h;
        int       k;
        o.ov = 1'b1;
        o.ax = aapr_pkg::AXIS_X;
        o.ma = '0;
        o.mb = '0;
        for (k = 0; k < 3; k++)
        begin
            if (!(lane_of(p.b_min, k) <= lane_of(p.a_max, k) &&
                  lane_of(p.a_min, k) <= lane_of(p.b_max, k)))
                o.ov = 1'b0;
        end
        if (o.ov)
        begin
            if (p.a_fix && p.b_fix)
            begin
                r    = push_along(p.a_min, p.a_max, p.b_min, p.b_max);
                o.ax = r.ax;
            end
            else if (p.a_fix)
            begin
                // B is the free box, so B is the first box of the pair
                r    = push_along(p.b_min, p.b_max, p.a_min, p.a_max);
                o.ax = r.ax;
                o.mb = (CW+1)'(r.v);
            end
            else if (p.b_fix)
            begin
                r    = push_along(p.a_min, p.a_max, p.b_min, p.b_max);
                o.ax = r.ax;
                o.ma = (CW+1)'(r.v);
            end
            else
            begin
                // both free: floor half to A, negated half to B
                r    = push_along(p.a_min, p.a_max, p.b_min, p.b_max);
                h    = r.v >>> 1;
                o.ax = r.ax;
                o.ma = (CW+1)'(h);
                o.mb = (CW+1)'(-h);
            end
        end
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic logic [BW-1:0] corner(int x, int y, int z);
        return {CW'(z), CW'(y), CW'(x)};
    endfunction

    function automatic logic [BW-1:0] rand_box();
        return BW'({$urandom(), $urandom()});
    endfunction

    task automatic queue_pair(logic [BW-1:0] amn, logic [BW-1:0] amx,
                              logic [BW-1:0] bmn, logic [BW-1:0] bmx,
                              logic af, logic bf);
        pair_t p;
        p.a_min = amn;
        p.a_max = amx;
        p.b_min = bmn;
        p.b_max = bmx;
        p.a_fix = af;
        p.b_fix = bf;
        pair_q.push_back(p);
    endtask

    // A = [0,1000] on every axis, B starts d below A's max and runs well past
    // it, so the depth on each axis is exactly d with a negative push.
    task automatic stack_pair(int dx, int dy, int dz, logic af, logic bf);
        queue_pair(corner(0, 0, 0), corner(1000, 1000, 1000),
                   corner(1000 - dx, 1000 - dy, 1000 - dz), corner(1100, 1100, 1100),
                   af, bf);
    endtask

    // Random pair. Most are overlapping boxes with lanes drawn at a random
    // scale, so both tiny and full-range depths show up; the rest are
    // separated on one axis, inverted corners, forced axis ties, or raw bits.
    function automatic pair_t gen_pair();
        pair_t p;
        int    v[4];
        int    kind;
        int    cut;
        int    s;
        int    half;
        int    base;
        int    tmp;
        int    i;
        int    j;
        int    k;
        int    amn;
        int    amx;
        int    bmn;
        int    bmx;
        p.a_fix = 1'($urandom_range(1));
        p.b_fix = 1'($urandom_range(1));
        kind    = $urandom_range(99);
        if (kind >= 88)
        begin
            p.a_min = rand_box();
            p.a_max = rand_box();
            p.b_min = rand_box();
            p.b_max = rand_box();
            return p;
        end
        cut = $urandom_range(2);
        for (k = 0; k < 3; k++)
        begin
            s    = $urandom_range(16, 1);
            half = 1 << (s - 1);
            base = int'($urandom_range(65536 - 2 * half)) - 32768 + half;
            for (j = 0; j < 4; j++)
                v[j] = base + int'($urandom_range(2 * half - 1)) - half;
            for (i = 0; i < 3; i++)
                for (j = 0; j < 3 - i; j++)
                    if (v[j] > v[j+1])
                    begin
                        tmp    = v[j];
                        v[j]   = v[j+1];
                        v[j+1] = tmp;
                    end
            if ($urandom_range(7) == 0)
                v[2] = v[1];              // faces just touching
            if (kind >= 55 && kind < 70 && k == cut)
            begin
                amn = v[0]; amx = v[1]; bmn = v[2]; bmx = v[3];
                if ($urandom_range(1))
                begin
                    amn = v[2]; amx = v[3]; bmn = v[0]; bmx = v[1];
                end
            end
            else
            begin
                case ($urandom_range(3))
                    0: begin amn = v[0]; amx = v[2]; bmn = v[1]; bmx = v[3]; end
                    1: begin amn = v[1]; amx = v[3]; bmn = v[0]; bmx = v[2]; end
                    2: begin amn = v[0]; amx = v[3]; bmn = v[1]; bmx = v[2]; end
                    default: begin amn = v[1]; amx = v[2]; bmn = v[0]; bmx = v[3]; end
                endcase
            end
            if (kind >= 70 && kind < 80)
            begin
                if ($urandom_range(1))
                begin
                    tmp = amn; amn = amx; amx = tmp;
                end
                if ($urandom_range(1))
                begin
                    tmp = bmn; bmn = bmx; bmx = tmp;
                end
            end
            p.a_min[k*CW +: CW] = CW'(amn);
            p.a_max[k*CW +: CW] = CW'(amx);
            p.b_min[k*CW +: CW] = CW'(bmn);
            p.b_max[k*CW +: CW] = CW'(bmx);
        end
        if (kind >= 80 && kind < 88)
        begin
            // same geometry on several axes, so depths tie across axes
            for (k = 1; k < 3; k++)
                if (k == 1 || $urandom_range(1))
                begin
                    p.a_min[k*CW +: CW] = p.a_min[0 +: CW];
                    p.a_max[k*CW +: CW] = p.a_max[0 +: CW];
                    p.b_min[k*CW +: CW] = p.b_min[0 +: CW];
                    p.b_max[k*CW +: CW] = p.b_max[0 +: CW];
                end
        end
        return p;
    endfunction

    // Hold off new items until the pipe is empty and every result is back.
    task automatic drain();
        while (pair_q.size() > 0 || start || due_q.size() > 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: changes inputs on the falling edge. An item stays on the ports
    // until a rising edge takes it; idle gaps are mostly short, a few long,
    // with occasional gap-free bursts. Junk sits on the fields while idle.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_proc
        pair_t p;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || taken)
        begin
            if (gap_left > 0 || pair_q.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left = gap_left - 1;
                start     <= 1'b0;
                box_a_min <= rand_box();
                box_a_max <= rand_box();
                box_b_min <= rand_box();
                box_b_max <= rand_box();
                a_fixed   <= 1'($urandom_range(1));
                b_fixed   <= 1'($urandom_range(1));
            end
            else
            begin
                p = pair_q.pop_front();
                box_a_min <= p.a_min;
                box_a_max <= p.a_max;
                box_b_min <= p.b_min;
                box_b_max <= p.b_max;
                a_fixed   <= p.a_fix;
                b_fixed   <= p.b_fix;
                start     <= 1'b1;
                if (burst_left > 0)
                begin
                    burst_left = burst_left - 1;
                    gap_left   = 0;
                end
                else
                begin
                    case ($urandom_range(19))
                        0:          gap_left = $urandom_range(60, 20);
                        1, 2:       gap_left = $urandom_range(10, 4);
                        3:          begin burst_left = $urandom_range(60, 20); gap_left = 0; end
                        4, 5, 6, 7,
                        8, 9, 10:   gap_left = $urandom_range(3, 1);
                        default:    gap_left = 0;
                    endcase
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: samples on the rising edge. A done strobe is checked against
    // the oldest prediction; an item taken at this edge is predicted and
    // queued. The check goes first so a strobe never pairs with a same-edge
    // prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_proc
        pair_t    p;
        outcome_t want;
        taken <= rst_n && start && !busy;
        if (rst_n && done)
        begin
            n_checked++;
            if (due_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected: ov=%0b axis=%0d a=%0d b=%0d",
                         $time, overlapping, push_axis, move_a, move_b);
            end
            else
            begin
                want = due_q.pop_front();
                if (overlapping !== want.ov || push_axis !== want.ax ||
                    move_a !== want.ma || move_b !== want.mb)
                begin
                    errors++;
                    if (n_reported < MAX_REPORTS)
                        $display({"%0t: mismatch: expected ov=%0b axis=%0d a=%0d b=%0d,",
                                  " got ov=%0b axis=%0d a=%0d b=%0d"},
                                 $time, want.ov, want.ax, want.ma, want.mb,
                                 overlapping, push_axis, move_a, move_b);
                    else if (n_reported == MAX_REPORTS)
                        $display("%0t: further mismatch reports suppressed", $time);
                    n_reported++;
                end
            end
        end
        if (rst_n && start && !busy)
        begin
            p.a_min = box_a_min;
            p.a_max = box_a_max;
            p.b_min = box_b_min;
            p.b_max = box_b_max;
            p.a_fix = a_fixed;
            p.b_fix = b_fixed;
            want = mtv_predict(p);
            due_q.push_back(want);
            n_sent++;
            if (want.ov)
            begin
                n_overlap++;
                if (p.a_fix && p.b_fix)
                    n_both++;
                else if (p.a_fix)
                    n_afix++;
                else if (p.b_fix)
                    n_bfix++;
                else
                    n_free++;
            end
        end
    end

    // Watchdog: ends the run when no item goes in or comes out for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("** aabb_penetration_resolver: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed pairs, drain, random phase, drain, random
    // phase, then wait out the pipe and report.
    // ------------------------------------------------------------------------
    initial
    begin : run_proc
        int n;
        int i;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Zero-size boxes at the origin, all four fixed combinations.
        for (i = 0; i < 4; i++)
            queue_pair('0, '0, '0, '0, i[0], i[1]);

        // Identical full-range boxes: depth 65535, odd negative halving.
        for (i = 0; i < 4; i++)
            queue_pair(corner(-32768, -32768, -32768), corner(32767, 32767, 32767),
                       corner(-32768, -32768, -32768), corner(32767, 32767, 32767),
                       i[0], i[1]);

        // Far apart at opposite extremes: no overlap.
        queue_pair(corner(32767, 32767, 32767), corner(32767, 32767, 32767),
                   corner(-32768, -32768, -32768), corner(-32768, -32768, -32768),
                   1'b0, 1'b0);

        // All lanes -1 against a box reaching up to 0.
        queue_pair('1, '1, '1, '0, 1'b0, 1'b1);

        // Faces touching on x: zero depth still counts as overlap.
        queue_pair(corner(0, 0, 0), corner(16, 400, 400),
                   corner(16, -400, -400), corner(32, 800, 800), 1'b0, 1'b0);

        // Axis choice and tie order.
        stack_pair(5, 5, 9, 1'b0, 1'b0);    // x wins tie with y
        stack_pair(9, 5, 5, 1'b1, 1'b0);    // y wins tie with z
        stack_pair(9, 7, 3, 1'b0, 1'b1);    // z is least
        stack_pair(3, 3, 3, 1'b1, 1'b1);    // three-way tie, both fixed

        // B overlaps A's low side: positive push, even and odd depths.
        queue_pair(corner(100, 100, 100), corner(200, 200, 200),
                   corner(50, 50, 50), corner(120, 500, 500), 1'b0, 1'b1);
        queue_pair(corner(100, 100, 100), corner(200, 200, 200),
                   corner(50, 50, 50), corner(121, 500, 500), 1'b0, 1'b0);

        // Inverted corners on A, taken as given.
        queue_pair(corner(300, 300, 300), corner(100, 100, 100),
                   corner(50, 50, 50), corner(350, 350, 350), 1'b1, 1'b0);

        drain();

        for (n = 0; n < 2; n++)
        begin
            for (i = 0; i < RANDOM_ITEMS; i++)
                pair_q.push_back(gen_pair());
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d box pairs and %0d checked results, %0d overlapping.",
                 n_sent, n_checked, n_overlap);
        $display("Overlaps by mode: both free %0d, A fixed %0d, B fixed %0d, both fixed %0d.",
                 n_free, n_afix, n_bfix, n_both);
        if (errors == 0 && due_q.size() == 0)
        begin
            $display("** aabb_penetration_resolver: PASSED **");
        end
        else
        begin
            $display("%0d errors, %0d results never arrived", errors, due_q.size());
            $display("** aabb_penetration_resolver: FAILED **");
        end
        $finish;
    end

endmodule
